// ===== rtl/taq_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle angle quality test: shared definitions
// Widths of the coordinate, edge, product and compare paths, the threshold
// register layout and the corner codes shared by the top level and the
// corner datapath.
// ----------------------------------------------------------------------------
package taq_pkg;

    localparam int COORD_BITS = 24;
    // Edge component: difference of two coordinates.
    localparam int EDGE_W = COORD_BITS + 1;
    // Product of a pair of edge components, squared lengths and dot magnitudes.
    localparam int PROD_W = 2 * EDGE_W;
    localparam int MAG_W  = PROD_W;
    // Wide products are cut into halves of this width for the multipliers.
    localparam int HALF_W = MAG_W / 2;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int CHUNKS = SQ_W / HALF_W;

    localparam int THR_W     = 17;
    localparam int FRAC_BITS = 16;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(55938);

    localparam int TP_W  = HALF_W + THR_W;
    localparam int RHS_W = SQ_W + THR_W;

    localparam int IN_TDATA_W  = ((6 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    // Accept to result valid, in cycles.
    localparam int LATENCY = 8;

    typedef enum logic [1:0] {
        CORNER_ORG  = 2'd0,
        CORNER_DEST = 2'd1,
        CORNER_APEX = 2'd2,
        CORNER_NONE = 2'd3
    } t_corner;

    typedef struct packed {
        logic signed [EDGE_W-1:0] x;
        logic signed [EDGE_W-1:0] y;
    } t_edge;

endpackage

// ===== rtl/triangle_angle_quality_test.sv =====
// ----------------------------------------------------------------------------
// Triangle angle quality test
// Flags a triangle whose smallest angle is below the minimum or whose largest
// is above 180 degrees minus it, and names the first failing corner.
// ----------------------------------------------------------------------------
// Input stream: one transfer carries one triangle, the six coordinates
// packed in tdata. Output stream: one transfer per triangle with is_bad and
// bad_corner (org, dest, apex, or none when the triangle passes).
// The threshold register holds cos^2 of the minimum angle in Q1.16. Write it
// through i_cfg_we / i_cfg_wdata only while no triangle is in flight; the
// block itself does not enforce this. One triangle is taken every cycle
// while the output is not held; the pipeline of edge, product and compare
// stages holds up to 8 triangles, one per stage.
// All stages advance together. When the output holds a result that the
// receiver does not take, the whole pipeline holds and o_s_axis_tready drops;
// nothing is lost or repeated. A held result stays on the output unchanged.
// Reset empties the pipeline and sets the threshold to about 22.5 degrees.
// ----------------------------------------------------------------------------
module triangle_angle_quality_test
    import taq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // org_x, org_y, dest_x, dest_y, apex_x, apex_y from the lowest bit up
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // is_bad, bad_corner from the lowest bit up, zero padded
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [THR_W-1:0]       i_cfg_wdata
);

    logic [THR_W-1:0]      r_thr;
    logic [LATENCY-1:0]    r_vld;
    logic                  en;

    logic [COORD_BITS-1:0] vx [3];
    logic [COORD_BITS-1:0] vy [3];
    t_edge                 n_edge [3];
    t_edge                 r_edge [3];
    logic [PROD_W-1:0]     r_sqx [3];
    logic [PROD_W-1:0]     r_sqy [3];
    logic [MAG_W-1:0]      r_len [3];
    logic [2:0]            fail;

    logic                  r_is_bad;
    t_corner               r_bad_corner;
    logic                  n_is_bad;
    t_corner               n_bad_corner;

    assign en              = !r_vld[LATENCY-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[LATENCY-1];
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-3){1'b0}}, r_bad_corner, r_is_bad};

    // Edge i lies opposite vertex i and runs from vertex i+2 to vertex i+1.
    always_comb begin
        for (int v = 0; v < 3; v++) begin
            vx[v] = i_s_axis_tdata[(2*v)*COORD_BITS +: COORD_BITS];
            vy[v] = i_s_axis_tdata[(2*v+1)*COORD_BITS +: COORD_BITS];
        end
        for (int i = 0; i < 3; i++) begin
            n_edge[i].x = {vx[(i+1)%3][COORD_BITS-1], vx[(i+1)%3]}
                        - {vx[(i+2)%3][COORD_BITS-1], vx[(i+2)%3]};
            n_edge[i].y = {vy[(i+1)%3][COORD_BITS-1], vy[(i+1)%3]}
                        - {vy[(i+2)%3][COORD_BITS-1], vy[(i+2)%3]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (en) begin
                r_vld <= {r_vld[LATENCY-2:0], i_s_axis_tvalid};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_edge[i] <= n_edge[i];
                r_sqx[i]  <= PROD_W'(r_edge[i].x * r_edge[i].x);
                r_sqy[i]  <= PROD_W'(r_edge[i].y * r_edge[i].y);
                r_len[i]  <= r_sqx[i] + r_sqy[i];
            end
            r_is_bad     <= n_is_bad;
            r_bad_corner <= n_bad_corner;
        end
    end

    // Corner i is formed by the pair of edges that do not lie opposite it.
    for (genvar g = 0; g < 3; g++) begin : g_corner
        taq_corner u_corner (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_edge_a (r_edge[(g+1)%3]),
            .i_edge_b (r_edge[(g+2)%3]),
            .i_len_a  (r_len[(g+1)%3]),
            .i_len_b  (r_len[(g+2)%3]),
            .i_thr    (r_thr),
            .o_fail   (fail[g])
        );
    end

    always_comb begin
        n_is_bad = 1'b1;
        priority if (fail[0]) begin
            n_bad_corner = CORNER_ORG;
        end else if (fail[1]) begin
            n_bad_corner = CORNER_DEST;
        end else if (fail[2]) begin
            n_bad_corner = CORNER_APEX;
        end else begin
            n_bad_corner = CORNER_NONE;
            n_is_bad     = 1'b0;
        end
    end

endmodule

// ===== rtl/taq_corner.sv =====
// ----------------------------------------------------------------------------
// Triangle angle quality test: corner datapath
// Tests a single corner: forms the dot product of the pair of edges that meet
// there, squares it, multiplies both squared lengths and the threshold, and
// compares both sides. Wide products are split into half-width partials.
// ----------------------------------------------------------------------------
module taq_corner
    import taq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  t_edge            i_edge_a,
    input  t_edge            i_edge_b,
    input  logic [MAG_W-1:0] i_len_a,
    input  logic [MAG_W-1:0] i_len_b,
    input  logic [THR_W-1:0] i_thr,
    output logic             o_fail
);

    // Stage 2: component products.
    logic signed [PROD_W-1:0] r_p1, r_p2;
    // Stage 3: dot magnitude.
    logic signed [MAG_W:0]    dot_sum;
    logic [MAG_W-1:0]         n_dmag, r_dmag;
    // Stage 4: half-width partial products.
    logic [MAG_W-1:0] r_d_hh, r_d_hl, r_d_ll;
    logic [MAG_W-1:0] r_l_hh, r_l_hl, r_l_lh, r_l_ll;
    // Stage 5: full squares and length product.
    logic [SQ_W-1:0]  r_dsq, r_lprod;
    // Stage 6: threshold partial products.
    logic [TP_W-1:0]  r_tp [CHUNKS];
    logic [SQ_W-1:0]  r_dsq6;
    // Stage 7: both sides of the compare.
    logic [RHS_W-1:0] n_rhs, r_rhs;
    logic [SQ_W-1:0]  r_dsq7;
    logic [RHS_W-1:0] lhs;

    logic [HALF_W-1:0] d_hi, d_lo, a_hi, a_lo, b_hi, b_lo;

    assign dot_sum = {r_p1[PROD_W-1], r_p1} + {r_p2[PROD_W-1], r_p2};
    assign n_dmag  = dot_sum[MAG_W] ? MAG_W'(~dot_sum + 1'b1) : MAG_W'(dot_sum);

    assign d_hi = r_dmag[MAG_W-1:HALF_W];
    assign d_lo = r_dmag[HALF_W-1:0];
    assign a_hi = i_len_a[MAG_W-1:HALF_W];
    assign a_lo = i_len_a[HALF_W-1:0];
    assign b_hi = i_len_b[MAG_W-1:HALF_W];
    assign b_lo = i_len_b[HALF_W-1:0];

    always_comb begin
        n_rhs = '0;
        for (int k = 0; k < CHUNKS; k++) begin
            n_rhs = n_rhs + (RHS_W'(r_tp[k]) << (k * HALF_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= i_edge_a.x * i_edge_b.x;
            r_p2   <= i_edge_a.y * i_edge_b.y;
            r_dmag <= n_dmag;

            // The squared lengths arrive registered, aligned with r_dmag.
            r_d_hh <= d_hi * d_hi;
            r_d_hl <= d_hi * d_lo;
            r_d_ll <= d_lo * d_lo;
            r_l_hh <= a_hi * b_hi;
            r_l_hl <= a_hi * b_lo;
            r_l_lh <= a_lo * b_hi;
            r_l_ll <= a_lo * b_lo;

            r_dsq   <= (SQ_W'(r_d_hh) << (2 * HALF_W))
                     + (SQ_W'(r_d_hl) << (HALF_W + 1))
                     + SQ_W'(r_d_ll);
            r_lprod <= (SQ_W'(r_l_hh) << (2 * HALF_W))
                     + ((SQ_W'(r_l_hl) + SQ_W'(r_l_lh)) << HALF_W)
                     + SQ_W'(r_l_ll);

            for (int k = 0; k < CHUNKS; k++) begin
                r_tp[k] <= r_lprod[k*HALF_W +: HALF_W] * i_thr;
            end
            r_dsq6 <= r_dsq;

            r_rhs  <= n_rhs;
            r_dsq7 <= r_dsq6;
        end
    end

    // Strict compare: a zero-length edge makes both sides zero and passes.
    assign lhs    = RHS_W'(r_dsq7) << FRAC_BITS;
    assign o_fail = lhs > r_rhs;

endmodule
